// ----- design/vectored_irq_timer_gpio_usart_peripheral_assert.svh -----
// Assertion macros for the peripheral
`ifndef VECTORED_IRQ_TIMER_GPIO_USART_PERIPHERAL_ASSERT_SVH
`define VECTORED_IRQ_TIMER_GPIO_USART_PERIPHERAL_ASSERT_SVH
`define VITP_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define VITP_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- design/vitp_pkg.sv -----
`timescale 1ns / 1ps
package vitp_pkg;
	typedef enum logic [2:0] {
		K_READ = 3'd0, K_WRITE = 3'd1, K_PIN = 3'd2, K_TICK = 3'd3, K_ACK = 3'd4, K_RX = 3'd5
	} kind_t;
	localparam logic [4:0] R_GPIP = 5'd0, R_AER = 5'd1, R_DDR = 5'd2, R_IERA = 5'd3,
		R_IERB = 5'd4, R_IPRA = 5'd5, R_IPRB = 5'd6, R_ISRA = 5'd7, R_ISRB = 5'd8,
		R_IMRA = 5'd9, R_IMRB = 5'd10, R_VR = 5'd11, R_TACR = 5'd12, R_TBCR = 5'd13,
		R_TCDCR = 5'd14, R_TADR = 5'd15, R_TBDR = 5'd16, R_TCDR = 5'd17, R_TDDR = 5'd18,
		R_SCR = 5'd19, R_UCR = 5'd20, R_RSR = 5'd21, R_TSR = 5'd22, R_UDR = 5'd23;
	localparam int CH_TX_EMPTY = 10;
	localparam int CH_RX_ERR = 11;
	localparam int CH_RX_FULL = 12;
	localparam logic [3:0] MODE_STOP = 4'd0;
	localparam logic [3:0] MODE_EVENT = 4'd8;
	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] reg_index;
		logic [7:0] write_data;
		logic [2:0] pin_index;
		logic [2:0] line_level;
		logic [7:0] rx_byte;
	} item_t;
	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_request;
		logic [2:0] irq_level_out;
		logic [7:0] irq_vector;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_ready;
	} result_t;
	// timer control for the four timers
	typedef struct packed {
		logic [7:0] ctl;
		logic [7:0] reload;
		logic [8:0] count;
		logic [7:0] pre;
		logic [7:0] evt;
	} timer_t;
	function automatic logic [7:0] prescale_div(input logic [2:0] m);
		case (m)
			3'd1: prescale_div = 8'd4;
			3'd2: prescale_div = 8'd10;
			3'd3: prescale_div = 8'd16;
			3'd4: prescale_div = 8'd50;
			3'd5: prescale_div = 8'd64;
			3'd6: prescale_div = 8'd100;
			3'd7: prescale_div = 8'd200;
			default: prescale_div = 8'd0;
		endcase
	endfunction
	function automatic logic [3:0] timer_chan(input logic [1:0] n);
		case (n)
			2'd0: timer_chan = 4'd13;
			2'd1: timer_chan = 4'd8;
			2'd2: timer_chan = 4'd5;
			default: timer_chan = 4'd4;
		endcase
	endfunction
	function automatic logic [3:0] pin_chan(input logic [2:0] n);
		case (n)
			3'd0: pin_chan = 4'd0;
			3'd1: pin_chan = 4'd1;
			3'd2: pin_chan = 4'd2;
			3'd3: pin_chan = 4'd3;
			3'd4: pin_chan = 4'd6;
			3'd5: pin_chan = 4'd7;
			3'd6: pin_chan = 4'd14;
			default: pin_chan = 4'd15;
		endcase
	endfunction
endpackage

// ----- design/vitp_timer.sv -----
`timescale 1ns / 1ps
module vitp_timer import vitp_pkg::*; (
	input  logic   [3:0] mode,
	input  timer_t       t,
	input  logic         tick,
	input  logic         evt_edge,
	output timer_t       t_next,
	output logic         raise,
	output logic   [7:0] rd
);
	logic [8:0] r;
	logic [8:0] c;
	logic [7:0] div;
	logic [7:0] er;
	logic [7:0] e1;
	always_comb begin
		r = (t.reload == 8'd0) ? 9'd256 : {1'b0, t.reload};
		c = (t.count == 9'd0 || t.count > r) ? r : t.count;
		if (mode == MODE_EVENT) rd = t.evt;
		else if (mode == MODE_STOP) rd = t.reload;
		else rd = c[7:0];
		div = prescale_div(mode[2:0]);
		er = (t.reload == 8'd0) ? 8'd255 : t.reload;
		t_next = t;
		raise = 1'b0;
		e1 = 8'd0;
		if (tick && mode != MODE_STOP && mode != MODE_EVENT && div != 8'd0) begin
			if (t.pre + 8'd1 < div) begin
				t_next.pre = t.pre + 8'd1;
			end else begin
				t_next.pre = 8'd0;
				if (t.count <= 9'd1 || t.count > r) begin
					t_next.count = r;
					raise = 1'b1;
				end else begin
					t_next.count = t.count - 9'd1;
				end
			end
		end
		if (evt_edge && mode == MODE_EVENT) begin
			e1 = ((t.evt == 8'd0) ? er : t.evt) - 8'd1;
			if (e1 == 8'd0) begin
				t_next.evt = er;
				raise = 1'b1;
			end else begin
				t_next.evt = e1;
			end
		end
	end
endmodule

// ----- design/vitp_core.sv -----
`timescale 1ns / 1ps
module vitp_core import vitp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   it,
	input  logic [2:0] level,
	output result_t res
);
	logic [7:0] pin_in_q, pin_out_q, aer_q, ddr_q, vr_q, scr_q, ucr_q, rsr_q, tsr_q, udr_q;
	logic [15:0] ier_q, ipr_q, isr_q, imr_q;
	logic [4:0] ack_q;
	timer_t tm_q [4];
	timer_t tm_d [4];
	timer_t tm_n [4];
	logic [3:0] tmode [4];
	logic [3:0] traise;
	logic [7:0] trd [4];
	logic [7:0] pin_in_d, pin_out_d, aer_d, ddr_d, vr_d, scr_d, ucr_d, rsr_d, tsr_d, udr_d;
	logic [15:0] ier_d, ipr_d, isr_d, imr_d, raise, act;
	logic [4:0] ack_d;
	logic [7:0] rd, m, txb;
	logic txv, hi, chg, pin_hit, ev_a, ev_b, tick;
	logic [1:0] tn;
	logic [4:0] ins, best;

	assign tick = (it.kind == K_TICK);
	assign m = 8'd1 << it.pin_index;
	assign hi = (it.line_level != 3'd0);
	assign chg = (it.kind == K_PIN) && (((pin_in_q & m) != 8'd0) != hi);
	assign pin_hit = chg && (hi == ((aer_q & m) != 8'd0));
	assign ev_a = pin_hit && (it.pin_index == 3'd4);
	assign ev_b = pin_hit && (it.pin_index == 3'd3);

	for (genvar g = 0; g < 4; g++) begin : g_tm
		assign tmode[g] = (g < 2) ? tm_q[g].ctl[3:0] : {1'b0, tm_q[g].ctl[2:0]};
		vitp_timer u_tm (
			.mode(tmode[g]), .t(tm_q[g]), .tick(tick),
			.evt_edge((g == 0) ? ev_a : ((g == 1) ? ev_b : 1'b0)),
			.t_next(tm_n[g]), .raise(traise[g]), .rd(trd[g])
		);
	end

	always_comb begin
		pin_in_d = pin_in_q; pin_out_d = pin_out_q; aer_d = aer_q; ddr_d = ddr_q;
		vr_d = vr_q; scr_d = scr_q; ucr_d = ucr_q; rsr_d = rsr_q; tsr_d = tsr_q;
		udr_d = udr_q; ier_d = ier_q; ipr_d = ipr_q; isr_d = isr_q; imr_d = imr_q;
		raise = 16'd0; rd = 8'd0; txv = 1'b0; txb = 8'd0;
		tn = 2'd0;
		for (int i = 0; i < 4; i++) tm_d[i] = tm_n[i];
		if (chg) begin
			pin_in_d = hi ? (pin_in_q | m) : (pin_in_q & ~m);
			if (pin_hit) begin
				raise[pin_chan(it.pin_index)] = 1'b1;
			end
		end
		for (int i = 0; i < 4; i++)
			if (traise[i]) raise[timer_chan(2'(i))] = 1'b1;
		case (it.kind)
			K_READ: begin
				case (it.reg_index)
					R_GPIP: rd = (pin_out_q & ddr_q) | (pin_in_q & ~ddr_q);
					R_AER: rd = aer_q;
					R_DDR: rd = ddr_q;
					R_IERA: rd = ier_q[15:8];
					R_IERB: rd = ier_q[7:0];
					R_IPRA: rd = ipr_q[15:8];
					R_IPRB: rd = ipr_q[7:0];
					R_ISRA: rd = isr_q[15:8];
					R_ISRB: rd = isr_q[7:0];
					R_IMRA: rd = imr_q[15:8];
					R_IMRB: rd = imr_q[7:0];
					R_VR: rd = vr_q;
					R_TACR: rd = tm_q[0].ctl;
					R_TBCR: rd = tm_q[1].ctl;
					R_TCDCR: rd = {tm_q[2].ctl[3:0], tm_q[3].ctl[3:0]};
					R_TADR: rd = trd[0];
					R_TBDR: rd = trd[1];
					R_TCDR: rd = trd[2];
					R_TDDR: rd = trd[3];
					R_SCR: rd = scr_q;
					R_UCR: rd = ucr_q;
					R_RSR: rd = rsr_q;
					R_TSR: rd = tsr_q;
					R_UDR: begin
						rd = udr_q;
						rsr_d[7] = 1'b0;
					end
					default: rd = 8'd0;
				endcase
			end
			K_WRITE: begin
				case (it.reg_index)
					R_GPIP: pin_out_d = it.write_data;
					R_AER: aer_d = it.write_data;
					R_DDR: ddr_d = it.write_data;
					R_IERA: begin
						ier_d[15:8] = it.write_data;
						ipr_d[15:8] = ipr_q[15:8] & it.write_data;
					end
					R_IERB: begin
						ier_d[7:0] = it.write_data;
						ipr_d[7:0] = ipr_q[7:0] & it.write_data;
					end
					R_IPRA: ipr_d[15:8] = ipr_q[15:8] & it.write_data;
					R_IPRB: ipr_d[7:0] = ipr_q[7:0] & it.write_data;
					R_ISRA: isr_d[15:8] = isr_q[15:8] & it.write_data;
					R_ISRB: isr_d[7:0] = isr_q[7:0] & it.write_data;
					R_IMRA: imr_d[15:8] = it.write_data;
					R_IMRB: imr_d[7:0] = it.write_data;
					R_VR: begin
						vr_d = it.write_data;
						if (!it.write_data[3]) isr_d = 16'd0;
					end
					R_TACR, R_TBCR: begin
						tn = (it.reg_index == R_TACR) ? 2'd0 : 2'd1;
						tm_d[tn].ctl = it.write_data;
						tm_d[tn].pre = 8'd0;
						tm_d[tn].count = (tm_q[tn].reload == 8'd0) ? 9'd256
							: {1'b0, tm_q[tn].reload};
					end
					R_TCDCR: begin
						tm_d[2].ctl = {4'd0, it.write_data[7:4]};
						tm_d[3].ctl = {4'd0, it.write_data[3:0]};
						for (int i = 2; i < 4; i++) begin
							tm_d[i].pre = 8'd0;
							tm_d[i].count = (tm_q[i].reload == 8'd0) ? 9'd256
								: {1'b0, tm_q[i].reload};
						end
					end
					R_TADR, R_TBDR, R_TCDR, R_TDDR: begin
						tn = 2'(it.reg_index - R_TADR);
						tm_d[tn].reload = it.write_data;
						tm_d[tn].evt = it.write_data;
						tm_d[tn].pre = 8'd0;
						tm_d[tn].count = (it.write_data == 8'd0) ? 9'd256
							: {1'b0, it.write_data};
					end
					R_SCR: scr_d = it.write_data;
					R_UCR: ucr_d = it.write_data;
					R_RSR: begin
						rsr_d[0] = it.write_data[0];
						if (!it.write_data[0]) rsr_d[7:6] = 2'b00;
					end
					R_TSR: begin
						tsr_d[0] = it.write_data[0];
						tsr_d[7] = it.write_data[0];
						raise[CH_TX_EMPTY] = it.write_data[0];
					end
					R_UDR: begin
						if (tsr_q[0]) begin
							txv = 1'b1;
							txb = it.write_data;
							tsr_d[7] = 1'b1;
							tsr_d[4] = 1'b1;
							raise[CH_TX_EMPTY] = 1'b1;
						end
					end
					default: ;
				endcase
			end
			K_ACK: begin
				if (it.line_level == level && ack_q[4]) begin
					ipr_d[ack_q[3:0]] = 1'b0;
					if (vr_q[3]) isr_d[ack_q[3:0]] = 1'b1;
				end
			end
			K_RX: begin
				if (rsr_q[0]) begin
					if (rsr_q[7]) begin
						rsr_d[6] = 1'b1;
						raise[CH_RX_ERR] = 1'b1;
					end else begin
						udr_d = it.rx_byte;
						rsr_d[7] = 1'b1;
						raise[CH_RX_FULL] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		ipr_d = ipr_d | (raise & ier_q);
		act = ipr_d & ier_d & imr_d;
		ins = 5'd0;
		best = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (isr_d[i]) ins = {1'b1, 4'(i)};
			if (act[i]) best = {1'b1, 4'(i)};
		end
		ack_d = (best[4] && !(ins[4] && ins[3:0] >= best[3:0])) ? best : 5'd0;
		res.read_data = rd;
		res.irq_request = ack_d[4];
		res.irq_level_out = ack_d[4] ? level : 3'd0;
		res.irq_vector = ack_d[4] ? {vr_d[7:4], ack_d[3:0]} : 8'd0;
		res.tx_valid = txv;
		res.tx_byte = txb;
		res.rx_ready = rsr_d[0] && !rsr_d[7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_in_q <= '0; pin_out_q <= '0; aer_q <= '0; ddr_q <= '0; vr_q <= '0;
			scr_q <= '0; ucr_q <= '0; rsr_q <= '0; tsr_q <= 8'h80; udr_q <= '0;
			ier_q <= '0; ipr_q <= '0; isr_q <= '0; imr_q <= '0; ack_q <= '0;
			for (int i = 0; i < 4; i++) tm_q[i] <= '0;
		end else if (en) begin
			pin_in_q <= pin_in_d; pin_out_q <= pin_out_d; aer_q <= aer_d; ddr_q <= ddr_d;
			vr_q <= vr_d; scr_q <= scr_d; ucr_q <= ucr_d; rsr_q <= rsr_d; tsr_q <= tsr_d;
			udr_q <= udr_d; ier_q <= ier_d; ipr_q <= ipr_d; isr_q <= isr_d;
			imr_q <= imr_d; ack_q <= ack_d;
			for (int i = 0; i < 4; i++) tm_q[i] <= tm_d[i];
		end
	end
endmodule

// ----- design/vectored_irq_timer_gpio_usart_peripheral.sv -----
`timescale 1ns / 1ps
// Multi-function peripheral: interrupt controller, GPIO, four timers, USART status.
// Slave stream (s_axis_*) carries one item per transfer: a bus read or write,
// a pin change, a timer tick, an interrupt acknowledge or a received byte;
// s_axis_tuser selects which one.
// Master stream (m_axis_*) returns exactly one result per item, reflecting
// the state after that item: read data, interrupt request/level/vector,
// transmitted byte and receiver ready.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one item per cycle unless the output stalls; all state updates are
// short combinational logic into the state registers and the result register.
// Stall: while m_axis_tready is low, the held result waits and s_axis_tready
// stays high only if the result register is free or being drained this cycle.
// cfg_* writes the CPU interrupt level (3 bits); write only while idle.
// Reset (arst_n low) clears all state but the result register, sets TSR buffer empty and level 6.
`include "vectored_irq_timer_gpio_usart_peripheral_assert.svh"
module vectored_irq_timer_gpio_usart_peripheral import vitp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// reg_index[4:0], write_data[12:5], pin_index[15:13],
	// line_level[18:16], rx_byte[26:19]
	input  logic [31:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], irq_request[8], irq_level_out[11:9], irq_vector[19:12],
	// tx_valid[20], tx_byte[28:21], rx_ready[29]
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	item_t it;
	result_t res, res_q;
	logic acc;
	logic [2:0] level_q;

	assign it.kind = s_axis_tuser;
	assign it.reg_index = s_axis_tdata[4:0];
	assign it.write_data = s_axis_tdata[12:5];
	assign it.pin_index = s_axis_tdata[15:13];
	assign it.line_level = s_axis_tdata[18:16];
	assign it.rx_byte = s_axis_tdata[26:19];
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	vitp_core u_core (
		.clk(clk), .arst_n(arst_n), .en(acc), .it(it), .level(level_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			level_q <= 3'd6;
		end else begin
			if (acc) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			if (cfg_valid) level_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) res_q <= res;
	end

	assign m_axis_tdata = {2'b00, res_q.rx_ready, res_q.tx_byte, res_q.tx_valid,
		res_q.irq_vector, res_q.irq_level_out, res_q.irq_request, res_q.read_data};

	`VITP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`VITP_ASSERT_IMPL(a_req_lvl, m_axis_tvalid && !m_axis_tdata[8],
		m_axis_tdata[11:9] == 3'd0 && m_axis_tdata[19:12] == 8'd0)
	`VITP_ASSERT_IMPL(a_tx, m_axis_tvalid && !m_axis_tdata[20], m_axis_tdata[28:21] == 8'd0)
	`VITP_ASSERT_NEXT(a_out, acc, m_axis_tvalid)
endmodule
